@@ src/linear_gradient_pixel_shader_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the linear gradient pixel shader core
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef LINEAR_GRADIENT_PIXEL_SHADER_CORE_DEFINES_SVH
`define LINEAR_GRADIENT_PIXEL_SHADER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside of reset.
`define LGPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The same check bound to the core clock and reset.
`define LGPS_ASSERT_CORE(label, ante, cons, msg) \
    `LGPS_ASSERT_IMPLIES(label, aclk, aresetn, ante, cons, msg)

`endif

@@ src/lgps_pkg.sv @@
// ---------------------------------------------------------------------------
// Linear gradient pixel shader package
// Transaction types, register indexes and code constants for the core.
// ---------------------------------------------------------------------------
package lgps_pkg;

    // Input commands.
    localparam logic CMD_RAMP_WRITE = 1'b0;
    localparam logic CMD_SHADE      = 1'b1;

    // Spread modes; the unused code behaves as pad.
    localparam logic [1:0] SPREAD_PAD     = 2'd0;
    localparam logic [1:0] SPREAD_REFLECT = 2'd1;
    localparam logic [1:0] SPREAD_REPEAT  = 2'd2;

    // Result write kinds.
    localparam logic [1:0] WK_NONE   = 2'd0;
    localparam logic [1:0] WK_OPAQUE = 2'd1;
    localparam logic [1:0] WK_BLEND  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAD_STEP_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAD_STEP_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAD_OFFSET = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_MODE = 2'd3;

    // Ramp geometry.
    localparam int unsigned RAMP_DEPTH  = 256;
    localparam int unsigned RAMP_SLOT_W = 8;
    localparam int unsigned COLOR_W     = 32;

    // Input transaction.
    typedef struct packed {
        logic        command;
        logic [7:0]  ramp_slot_in;
        logic [31:0] ramp_color;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  dst_red;
        logic [7:0]  dst_green;
        logic [7:0]  dst_blue;
        logic [7:0]  dst_alpha;
    } lgps_in_t;

    // Result transaction.
    typedef struct packed {
        logic [1:0] write_kind;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [7:0] ramp_slot_out;
    } lgps_out_t;

    // Configuration register file.
    typedef struct packed {
        logic signed [31:0] grad_step_x;
        logic signed [31:0] grad_step_y;
        logic signed [31:0] grad_offset;
        logic [1:0]         spread_mode;
    } lgps_cfg_t;

    // Item between coordinate, ramp and blend sections. The slot is the write
    // address for ramp writes and the lookup index for shaded pixels; the color
    // is the write data before the ramp and the ramp color after it.
    typedef struct packed {
        logic        command;
        logic [7:0]  ramp_slot;
        logic [31:0] ramp_color;
        logic [7:0]  dst_red;
        logic [7:0]  dst_green;
        logic [7:0]  dst_blue;
        logic [7:0]  dst_alpha;
    } lgps_mid_t;

endpackage

@@ src/lgps_coord.sv @@
// ---------------------------------------------------------------------------
// Gradient coordinate pipeline
// Four stages: products, sum, spread mapping and ramp index rounding.
// ---------------------------------------------------------------------------
module lgps_coord #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lgps_pkg::lgps_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  lgps_pkg::lgps_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lgps_pkg::lgps_mid_t out_item
);
    import lgps_pkg::*;

    // Twice the coordinate carries one more fraction bit.
    localparam int FB     = FRAC_BITS + 1;
    localparam int PROD_W = 32 + COORD_BITS + 2;
    localparam int U_W    = (COORD_BITS + 36 > FRAC_BITS + 19) ? COORD_BITS + 36
                                                               : FRAC_BITS + 19;
    localparam int M_W    = 16 + FB;
    localparam int S_W    = M_W + 8;
    localparam int IDX_LO = 15 + FB;

    localparam logic signed [U_W-1:0] BIAS   = {{(U_W-1){1'b0}}, 1'b1} << (14 + FB);
    localparam logic signed [U_W-1:0] PERIOD = {{(U_W-1){1'b0}}, 1'b1} << (15 + FB);
    localparam logic [M_W-1:0]        PERIOD_M = {1'b1, {(M_W-1){1'b0}}};
    localparam logic [S_W-1:0]        HALF   = {{(S_W-1){1'b0}}, 1'b1} << (14 + FB);

    // Stage valid bits and advance enables.
    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic       en1, en2, en3, en4;

    assign en4      = !vld_reg[3] || out_ready;
    assign en3      = !vld_reg[2] || en4;
    assign en2      = !vld_reg[1] || en3;
    assign en1      = !vld_reg[0] || en2;
    assign in_ready = en1;
    assign out_valid = vld_reg[3];

    always_comb begin
        vld_next = vld_reg;
        if (en1) vld_next[0] = in_valid;
        if (en2) vld_next[1] = vld_reg[0];
        if (en3) vld_next[2] = vld_reg[1];
        if (en4) vld_next[3] = vld_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: per-axis products at the pixel center, offset term.
    logic [COORD_BITS-1:0]    x_c, y_c;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [U_W-1:0]    offs_next, offs_reg;
    lgps_in_t                 item1_reg;

    assign x_c         = COORD_BITS'(in_item.pixel_x);
    assign y_c         = COORD_BITS'(in_item.pixel_y);
    assign prod_x_next = cfg.grad_step_x * $signed({1'b0, x_c, 1'b1});
    assign prod_y_next = cfg.grad_step_y * $signed({1'b0, y_c, 1'b1});
    assign offs_next   = (U_W'(cfg.grad_offset) <<< 1) + BIAS;

    // Stage 2: unwrapped coordinate.
    logic signed [U_W-1:0] u_next, u_reg;
    lgps_in_t              item2_reg;

    assign u_next = U_W'(prod_x_reg) + U_W'(prod_y_reg) + offs_reg;

    // Stage 3: spread mapping onto zero to one period.
    logic [M_W-1:0] r_fold;
    logic [M_W-1:0] m_next, m_reg;
    lgps_in_t       item3_reg;

    assign r_fold = u_reg[M_W-1:0];

    always_comb begin
        case (cfg.spread_mode)
            SPREAD_REPEAT: begin
                m_next = {1'b0, u_reg[M_W-2:0]};
            end
            SPREAD_REFLECT: begin
                // Above one period the fold is two periods minus the value.
                m_next = (r_fold > PERIOD_M) ? (~r_fold + 1'b1) : r_fold;
            end
            default: begin
                if (u_reg[U_W-1]) begin
                    m_next = '0;
                end else if (u_reg > PERIOD) begin
                    m_next = PERIOD_M;
                end else begin
                    m_next = u_reg[M_W-1:0];
                end
            end
        endcase
    end

    // Stage 4: index = round(m * 255 / period); the result never exceeds 255.
    logic [S_W-1:0] scaled;
    lgps_mid_t      out_next, out_reg;

    assign scaled = {m_reg, 8'b0} - S_W'(m_reg) + HALF;

    always_comb begin
        out_next.command    = item3_reg.command;
        out_next.ramp_slot  = (item3_reg.command == CMD_SHADE)
                              ? scaled[IDX_LO+7:IDX_LO] : item3_reg.ramp_slot_in;
        out_next.ramp_color = item3_reg.ramp_color;
        out_next.dst_red    = item3_reg.dst_red;
        out_next.dst_green  = item3_reg.dst_green;
        out_next.dst_blue   = item3_reg.dst_blue;
        out_next.dst_alpha  = item3_reg.dst_alpha;
    end

    assign out_item = out_reg;

    // Payload registers move with their stage enables.
    always_ff @(posedge aclk) begin
        if (en1) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            offs_reg   <= offs_next;
            item1_reg  <= in_item;
        end
        if (en2) begin
            u_reg     <= u_next;
            item2_reg <= item1_reg;
        end
        if (en3) begin
            m_reg     <= m_next;
            item3_reg <= item2_reg;
        end
        if (en4) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ src/lgps_ramp.sv @@
// ---------------------------------------------------------------------------
// Color ramp memory stage
// Single-port 256 x 32 ramp: stores ramp writes, looks up shaded pixels.
// ---------------------------------------------------------------------------
module lgps_ramp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lgps_pkg::lgps_mid_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lgps_pkg::lgps_mid_t out_item
);
    import lgps_pkg::*;

    logic [COLOR_W-1:0] ramp_mem [RAMP_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    lgps_mid_t          item_reg;
    logic               vld_reg;
    logic               take;

    assign in_ready  = !vld_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;

    // Stage valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    // One access per transaction, in pipeline order, so writes and reads
    // of the same entry keep their order.
    always_ff @(posedge aclk) begin
        if (take) begin
            if (in_item.command == CMD_RAMP_WRITE) begin
                ramp_mem[in_item.ramp_slot] <= in_item.ramp_color;
            end else begin
                rd_data_reg <= ramp_mem[in_item.ramp_slot];
            end
        end
        if (in_ready) begin
            item_reg <= in_item;
        end
    end

    // The looked-up color replaces the write data on the way out.
    always_comb begin
        out_item            = item_reg;
        out_item.ramp_color = rd_data_reg;
    end

endmodule

@@ src/lgps_blend.sv @@
// ---------------------------------------------------------------------------
// Alpha-over blend pipeline
// Two stages: channel products and kind select, then divide by 255.
// ---------------------------------------------------------------------------
module lgps_blend (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lgps_pkg::lgps_mid_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lgps_pkg::lgps_out_t out_item
);
    import lgps_pkg::*;

    // Exact floor(n / 255) for n up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = {1'b0, n} + 17'(n[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [1:0] vld_reg;
    logic       en1, en2;

    assign en2       = !vld_reg[1] || out_ready;
    assign en1       = !vld_reg[0] || en2;
    assign in_ready  = en1;
    assign out_valid = vld_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en1) vld_reg[0] <= in_valid;
            if (en2) vld_reg[1] <= vld_reg[0];
        end
    end

    // Stage 1: write kind, pass-through color and weighted channel sums.
    logic [7:0]  sr, sg, sb, sa, inv_a;
    logic [8:0]  alpha_sum;
    logic [7:0]  alpha_sat;
    logic [1:0]  kind_next, kind_reg;
    logic [31:0] direct_next, direct_reg;
    logic [7:0]  slot_next, slot_reg;
    logic [15:0] nr_next, ng_next, nb_next;
    logic [15:0] nr_reg, ng_reg, nb_reg;

    assign sr        = in_item.ramp_color[31:24];
    assign sg        = in_item.ramp_color[23:16];
    assign sb        = in_item.ramp_color[15:8];
    assign sa        = in_item.ramp_color[7:0];
    assign inv_a     = 8'd255 - sa;
    assign alpha_sum = {1'b0, in_item.dst_alpha} + {1'b0, sa};
    assign alpha_sat = alpha_sum[8] ? 8'd255 : alpha_sum[7:0];

    assign nr_next = 16'(sr) * 16'(sa) + 16'(in_item.dst_red)   * 16'(inv_a);
    assign ng_next = 16'(sg) * 16'(sa) + 16'(in_item.dst_green) * 16'(inv_a);
    assign nb_next = 16'(sb) * 16'(sa) + 16'(in_item.dst_blue)  * 16'(inv_a);

    always_comb begin
        slot_next = in_item.ramp_slot;
        if (in_item.command == CMD_RAMP_WRITE) begin
            // A ramp write reports an all-zero result.
            kind_next   = WK_NONE;
            direct_next = '0;
            slot_next   = '0;
        end else if (sa == 8'd0) begin
            kind_next   = WK_NONE;
            direct_next = {in_item.dst_red, in_item.dst_green,
                           in_item.dst_blue, in_item.dst_alpha};
        end else if (sa == 8'd255) begin
            kind_next   = WK_OPAQUE;
            direct_next = in_item.ramp_color;
        end else begin
            kind_next   = WK_BLEND;
            direct_next = {24'd0, alpha_sat};
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            kind_reg   <= kind_next;
            direct_reg <= direct_next;
            slot_reg   <= slot_next;
            nr_reg     <= nr_next;
            ng_reg     <= ng_next;
            nb_reg     <= nb_next;
        end
    end

    // Stage 2: divide the blended channels and form the result.
    lgps_out_t out_next, out_reg;
    logic      blend_sel;

    assign blend_sel = (kind_reg == WK_BLEND);

    always_comb begin
        out_next.write_kind    = kind_reg;
        out_next.out_red       = blend_sel ? div255(nr_reg) : direct_reg[31:24];
        out_next.out_green     = blend_sel ? div255(ng_reg) : direct_reg[23:16];
        out_next.out_blue      = blend_sel ? div255(nb_reg) : direct_reg[15:8];
        out_next.out_alpha     = direct_reg[7:0];
        out_next.ramp_slot_out = slot_reg;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

@@ src/linear_gradient_pixel_shader_core.sv @@
// ---------------------------------------------------------------------------
// Linear gradient pixel shader core
// Shades pixels from a linear gradient through a 256-entry RGBA ramp and
// composites the ramp color over the destination with alpha-over blending.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    lgps_in_t  (ramp write or pixel)
//   m_       out        m_valid / m_ready    lgps_out_t (one per transaction)
//   cfg_     in         cfg_wr_en            cfg_index, cfg_data
//
// One transaction is accepted per clock while the output is not stalled. A transaction
// passes four coordinate stages, the ramp read stage and two blend stages. The ramp
// memory port is used once per transaction.
// Reset clears the configuration and the stage valid bits; the ramp is not
// cleared and must be written before it is read.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and back-pressure reaches s_ready only when every stage is full.
//
module linear_gradient_pixel_shader_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lgps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lgps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lgps_pkg::lgps_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lgps_pkg::lgps_out_t                  m_data
);
    import lgps_pkg::*;

    `include "linear_gradient_pixel_shader_core_defines.svh"

    // Configuration registers.
    lgps_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRAD_STEP_X: cfg_next.grad_step_x = signed'(cfg_data);
                REG_GRAD_STEP_Y: cfg_next.grad_step_y = signed'(cfg_data);
                REG_GRAD_OFFSET: cfg_next.grad_offset = signed'(cfg_data);
                REG_SPREAD_MODE: cfg_next.spread_mode = cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Coordinate pipeline to ramp stage to blend pipeline.
    lgps_mid_t coord_item, ramp_item;
    logic      coord_valid, coord_ready;
    logic      ramp_valid, ramp_ready;

    lgps_coord #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (coord_valid),
        .out_ready (coord_ready),
        .out_item  (coord_item)
    );

    lgps_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (coord_valid),
        .in_ready  (coord_ready),
        .in_item   (coord_item),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_item  (ramp_item)
    );

    lgps_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_item   (ramp_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

    // Result kinds watched by the checks below.
    logic opaque_out, blend_out;

    assign opaque_out = m_valid && (m_data.write_kind == WK_OPAQUE);
    assign blend_out  = m_valid && (m_data.write_kind == WK_BLEND);

    // A taken result frees the whole stall chain back to the input.
    `LGPS_ASSERT_CORE(a_ready_chain, m_ready, s_ready, "input stalled while output drains")
    // An opaque replace always carries full ramp alpha.
    `LGPS_ASSERT_CORE(a_opaque_alpha, opaque_out, m_data.out_alpha == 8'd255, "opaque alpha")
    // A blended write adds a nonzero ramp alpha, so its alpha is never zero.
    `LGPS_ASSERT_CORE(a_blend_alpha, blend_out, m_data.out_alpha != 8'd0, "zero blend alpha")

endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the linear gradient pixel shader core
// Loads the color ramp, then runs directed corner cases and random traffic
// over several gradient settings. Each result is checked against a gradient
// and blend calculation kept in the scoreboard, while both handshakes idle
// and stall at random.
// ---------------------------------------------------------------------------
module tb;
    import lgps_pkg::*;

    localparam int PIPE_LATENCY   = 7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 165;

    // Tracks the configuration and ramp contents and holds the pixels that
    // are still due from the core.
    class gradient_scoreboard;
        logic signed [31:0] step_x = '0;
        logic signed [31:0] step_y = '0;
        logic signed [31:0] grad_offset = '0;
        logic [1:0]         spread = SPREAD_PAD;
        logic [31:0]        ramp [RAMP_DEPTH];
        lgps_out_t          expected_pixels [$];
        int                 errors = 0;

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRAD_STEP_X: step_x = data;
                REG_GRAD_STEP_Y: step_y = data;
                REG_GRAD_OFFSET: grad_offset = data;
                REG_SPREAD_MODE: spread = data[1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] blend_channel(int unsigned dst, int unsigned src,
                                           int unsigned alpha);
            return 8'((src * alpha + dst * (255 - alpha)) / 255);
        endfunction

        // Computes the result of one transaction and updates the ramp.
        function lgps_out_t shade_pixel(lgps_in_t it);
            longint      period;
            longint      u;
            longint      m;
            longint      slot;
            logic [31:0] col;
            int unsigned alpha;
            lgps_out_t   res;
            res = '0;
            if (it.command == CMD_RAMP_WRITE) begin
                ramp[it.ramp_slot_in] = it.ramp_color;
                return res;
            end

            // Twice the coordinate at the pixel center, with 17 fraction bits.
            period = longint'(1) <<< 32;
            u = longint'(step_x) * (2 * longint'(it.pixel_x) + 1)
              + longint'(step_y) * (2 * longint'(it.pixel_y) + 1)
              + 2 * longint'(grad_offset) + (longint'(16384) <<< 17);

            case (spread)
                SPREAD_REPEAT: m = u & (period - 1);
                SPREAD_REFLECT: begin
                    m = u & (2 * period - 1);
                    if (m > period) m = 2 * period - m;
                end
                default: m = (u < 0) ? 0 : ((u > period) ? period : u);
            endcase

            // Round to the nearest ramp entry.
            slot = (m * 255 + period / 2) >>> 32;
            if (slot > 255) slot = 255;
            col = ramp[slot[7:0]];
            alpha = col[7:0];
            res.ramp_slot_out = slot[7:0];

            if (alpha == 0) begin
                res.write_kind = WK_NONE;
                res.out_red    = it.dst_red;
                res.out_green  = it.dst_green;
                res.out_blue   = it.dst_blue;
                res.out_alpha  = it.dst_alpha;
            end else if (alpha == 255) begin
                res.write_kind = WK_OPAQUE;
                res.out_red    = col[31:24];
                res.out_green  = col[23:16];
                res.out_blue   = col[15:8];
                res.out_alpha  = col[7:0];
            end else begin
                res.write_kind = WK_BLEND;
                res.out_red    = blend_channel(it.dst_red, col[31:24], alpha);
                res.out_green  = blend_channel(it.dst_green, col[23:16], alpha);
                res.out_blue   = blend_channel(it.dst_blue, col[15:8], alpha);
                res.out_alpha  = (it.dst_alpha + alpha > 255) ? 8'hFF
                                                              : 8'(it.dst_alpha + alpha);
            end
            return res;
        endfunction

        function void note_input(lgps_in_t it);
            expected_pixels.insert(expected_pixels.size(), shade_pixel(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(lgps_out_t got);
            lgps_out_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with no transaction outstanding: expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("write_kind", 8'(want.write_kind), 8'(got.write_kind));
            compare_field("out_red", want.out_red, got.out_red);
            compare_field("out_green", want.out_green, got.out_green);
            compare_field("out_blue", want.out_blue, got.out_blue);
            compare_field("out_alpha", want.out_alpha, got.out_alpha);
            compare_field("ramp_slot_out", want.ramp_slot_out, got.ramp_slot_out);
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    lgps_in_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    lgps_out_t              m_data;

    gradient_scoreboard sb = new;
    int  send_quiet = 0;
    int  stall_cycles = 0;
    bit  hold_req = 1'b0;

    always #2 aclk = ~aclk;

    linear_gradient_pixel_shader_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Draws an idle gap, with occasional stretches of back-to-back transactions.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) quiet = $urandom_range(16, 96);
        return $urandom_range(0, 17);
    endfunction

    function automatic lgps_in_t random_item(logic cmd);
        logic [127:0] raw;
        lgps_in_t     it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(lgps_in_t)-1:0];
        it.command = cmd;
        // Favor the transparent and opaque alpha values.
        case ($urandom_range(0, 3))
            0: it.ramp_color[7:0] = 8'h00;
            1: it.ramp_color[7:0] = 8'hFF;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) it.pixel_x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        if ($urandom_range(0, 7) == 0) it.pixel_y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        return it;
    endfunction

    function automatic lgps_in_t ramp_entry(logic [7:0] slot, logic [31:0] color);
        lgps_in_t it;
        it = random_item(CMD_RAMP_WRITE);
        it.ramp_slot_in = slot;
        it.ramp_color = color;
        return it;
    endfunction

    function automatic lgps_in_t pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dst);
        lgps_in_t it;
        it = random_item(CMD_SHADE);
        it.pixel_x = x;
        it.pixel_y = y;
        {it.dst_red, it.dst_green, it.dst_blue, it.dst_alpha} = dst;
        return it;
    endfunction

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            4: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // Offers one transaction after a random gap and returns once it is taken.
    // Called and returning at a falling edge.
    task automatic send_item(input lgps_in_t it);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every result is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [31:0] sx, input logic [31:0] sy,
                                input logic [31:0] off, input logic [1:0] mode);
        write_reg(REG_GRAD_STEP_X, sx);
        write_reg(REG_GRAD_STEP_Y, sy);
        write_reg(REG_GRAD_OFFSET, off);
        write_reg(REG_SPREAD_MODE, {30'b0, mode});
        cfg_wr_en <= 1'b0;
    endtask

    // Two pixels at opposite corners under the current setting.
    task automatic corner_pixels();
        send_item(pixel(12'h000, 12'h000, $urandom));
        send_item(pixel(12'hFFF, 12'hFFF, $urandom));
    endtask

    task automatic run_phase(input int count, input int hold_point);
        int i;
        for (i = 0; i < count; i++) begin
            if (i == hold_point) hold_req = 1'b1;
            send_item(random_item(($urandom_range(0, 6) == 0) ? CMD_RAMP_WRITE : CMD_SHADE));
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        int quiet;
        quiet = 0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(quiet);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Transaction monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int i;
        lgps_in_t it;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Fill the whole ramp so that no pixel reads an unwritten entry.
        for (i = 0; i < RAMP_DEPTH; i++) begin
            it = random_item(CMD_RAMP_WRITE);
            it.ramp_slot_in = i[7:0];
            send_item(it);
        end

        // Reset setting puts every pixel on the middle entry: walk its alpha.
        send_item(ramp_entry(8'd128, 32'h1122_3300));
        send_item(pixel(12'h000, 12'h000, 32'hFFFF_FFFF));
        send_item(ramp_entry(8'd128, 32'hA5C3_E1FF));
        send_item(pixel(12'hFFF, 12'hFFF, 32'h0000_0000));
        send_item(ramp_entry(8'd128, 32'hFFFF_FF01));
        send_item(pixel(12'hFFF, 12'h000, 32'h0000_00FF));
        send_item(ramp_entry(8'd128, 32'h00FF_80FE));
        send_item(pixel(12'h000, 12'hFFF, 32'hFF00_7F01));
        drain();

        // Extreme coefficients under each spread mode, including the unused code.
        apply_config(32'h7FFF_FFFF, 32'h0, 32'h0, SPREAD_PAD);
        corner_pixels();
        drain();
        apply_config(32'h8000_0000, 32'h0, 32'h0, SPREAD_PAD);
        corner_pixels();
        drain();
        apply_config(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, SPREAD_REFLECT);
        corner_pixels();
        drain();
        apply_config(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, SPREAD_REPEAT);
        corner_pixels();
        drain();
        apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2'd3);
        corner_pixels();
        drain();

        // Random traffic under random settings; one phase stalls the result side.
        for (i = 0; i < PHASE_COUNT; i++) begin
            apply_config(pick_coeff(), pick_coeff(),
                         $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000,
                         2'($urandom_range(0, 3)));
            run_phase(PHASE_ITEMS, (i == 1) ? 20 : -1);
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/lgps_pkg.sv
src/lgps_coord.sv
src/lgps_ramp.sv
src/lgps_blend.sv
src/linear_gradient_pixel_shader_core.sv
bench/tb.sv
